@@ rtl/gdd_pkg.sv @@
// Gregorian date difference: shared widths, constants, stage-enable types and month tables.
// No dependencies; imported by every module of the block.
package gdd_pkg;

    localparam int DAY_W    = 5;
    localparam int MONTH_W  = 4;
    localparam int YEAR_W   = 14;
    localparam int DIFF_W   = 23;
    localparam int MAX_YEAR = 9999;

    // serial day number, wide enough for any 14-bit year
    localparam int DN_W     = 23;
    localparam int DELTA_W  = DN_W + 1;
    localparam int SUM_W    = DELTA_W + 1;
    localparam int DIFF_MAX = 2 ** (DIFF_W - 1) - 1;

    // y / 100 as (y * 5243) >> 19, exact for y below 43690
    localparam int DIV100_MUL   = 5243;
    localparam int DIV100_SHIFT = 19;
    localparam int MUL_W        = YEAR_W + 14;
    localparam int Q100_W       = YEAR_W - 6;
    localparam int OFF_W        = 9;

    localparam int DAYS_PER_YEAR = 365;
    localparam int FEB_LEAP_DAYS = 29;

    localparam logic [MONTH_W-1:0] MONTH_JAN = MONTH_W'(1);
    localparam logic [MONTH_W-1:0] MONTH_FEB = MONTH_W'(2);
    localparam logic [MONTH_W-1:0] MONTH_DEC = MONTH_W'(12);

    typedef logic [DAY_W-1:0] month_days_t [16];
    typedef logic [OFF_W-1:0] month_off_t [16];

    // month lengths, non-leap; unused codes read as zero
    localparam month_days_t MONTH_DAYS = '{
        5'd0,  5'd31, 5'd28, 5'd31, 5'd30, 5'd31, 5'd30, 5'd31,
        5'd31, 5'd30, 5'd31, 5'd30, 5'd31, 5'd0,  5'd0,  5'd0
    };

    // days from March 1 to the first of each month, March-based year
    localparam month_off_t MONTH_OFFSET = '{
        9'd0,   9'd306, 9'd337, 9'd0,   9'd31,  9'd61,  9'd92,  9'd122,
        9'd153, 9'd184, 9'd214, 9'd245, 9'd275, 9'd0,   9'd0,   9'd0
    };

    typedef struct packed {
        logic s1;
        logic s2;
        logic s3;
    } gdd_dn_en_t;

    typedef struct packed {
        logic s4;
        logic s5;
    } gdd_diff_en_t;

endpackage

@@ rtl/gdd_day_num.sv @@
// Three-stage serial day number of one date, with date validity check.
// Depends on gdd_pkg; stage enables come from the top-level flow control.
module gdd_day_num (
    input  logic                      clk,
    input  gdd_pkg::gdd_dn_en_t       en,
    input  logic [gdd_pkg::DAY_W-1:0]   day,
    input  logic [gdd_pkg::MONTH_W-1:0] month,
    input  logic [gdd_pkg::YEAR_W-1:0]  year,
    output logic [gdd_pkg::DN_W-1:0]    day_num,
    output logic                        date_ok
);
    import gdd_pkg::*;

    logic [DAY_W-1:0]   d1_reg;
    logic [MONTH_W-1:0] m1_reg;
    logic [YEAR_W-1:0]  y1_reg;
    logic [MUL_W-1:0]   prod1_reg;

    logic [Q100_W-1:0]  q100;
    logic [YEAR_W-1:0]  r100;
    logic               leap;
    logic [DAY_W-1:0]   mlen;
    logic               early;
    logic               ok_next;
    logic [YEAR_W-1:0]  yy_next;
    logic [Q100_W-1:0]  qy_next;

    logic [YEAR_W-1:0]  yy2_reg;
    logic [Q100_W-1:0]  qy2_reg;
    logic [OFF_W-1:0]   off2_reg;
    logic [DAY_W-1:0]   d2_reg;
    logic               ok2_reg;

    logic [DN_W-1:0]    dn_next;
    logic [DN_W-1:0]    dn3_reg;
    logic               ok3_reg;

    always_ff @(posedge clk)
    begin
        if (en.s1)
        begin
            d1_reg    <= day;
            m1_reg    <= month;
            y1_reg    <= year;
            prod1_reg <= MUL_W'(year) * MUL_W'(DIV100_MUL);
        end
    end

    always_comb
    begin
        q100    = prod1_reg[DIV100_SHIFT +: Q100_W];
        r100    = y1_reg - YEAR_W'(YEAR_W'(q100) * YEAR_W'(100));
        leap    = (y1_reg[1:0] == 2'b00) && ((r100 != '0) || (q100[1:0] == 2'b00));
        mlen    = (m1_reg == MONTH_FEB && leap) ? DAY_W'(FEB_LEAP_DAYS) : MONTH_DAYS[m1_reg];
        ok_next = (m1_reg >= MONTH_JAN) && (m1_reg <= MONTH_DEC)
                  && (y1_reg != '0) && (y1_reg <= YEAR_W'(MAX_YEAR))
                  && (d1_reg != '0) && (d1_reg <= mlen);
        early   = (m1_reg <= MONTH_FEB);
        yy_next = early ? y1_reg - YEAR_W'(1) : y1_reg;
        qy_next = (early && r100 == '0) ? q100 - Q100_W'(1) : q100;
    end

    always_ff @(posedge clk)
    begin
        if (en.s2)
        begin
            yy2_reg  <= yy_next;
            qy2_reg  <= qy_next;
            off2_reg <= MONTH_OFFSET[m1_reg];
            d2_reg   <= d1_reg;
            ok2_reg  <= ok_next;
        end
    end

    // 365*yy + yy/4 - yy/100 + yy/400 + month offset + day - 1
    assign dn_next = DN_W'(yy2_reg) * DN_W'(DAYS_PER_YEAR)
                     + DN_W'(yy2_reg >> 2)
                     + DN_W'(qy2_reg >> 2)
                     - DN_W'(qy2_reg)
                     + DN_W'(off2_reg)
                     + DN_W'(d2_reg)
                     - DN_W'(1);

    always_ff @(posedge clk)
    begin
        if (en.s3)
        begin
            dn3_reg <= dn_next;
            ok3_reg <= ok2_reg;
        end
    end

    assign day_num = dn3_reg;
    assign date_ok = ok3_reg;

endmodule

@@ rtl/gdd_diff.sv @@
// Two-stage subtract, end-day adjust and saturation of the day-number difference.
// Depends on gdd_pkg; stage enables come from the top-level flow control.
module gdd_diff (
    input  logic                       clk,
    input  gdd_pkg::gdd_diff_en_t      en,
    input  logic [gdd_pkg::DN_W-1:0]   first_num,
    input  logic [gdd_pkg::DN_W-1:0]   second_num,
    input  logic                       both_ok,
    input  logic                       include_end,
    output logic signed [gdd_pkg::DIFF_W-1:0] diff,
    output logic                       invalid
);
    import gdd_pkg::*;

    logic signed [DELTA_W-1:0] delta4_reg;
    logic                      inc4_reg;
    logic                      bad4_reg;

    logic signed [SUM_W-1:0]   sum;
    logic signed [DIFF_W-1:0]  diff_next;
    logic signed [DIFF_W-1:0]  diff5_reg;
    logic                      bad5_reg;

    always_ff @(posedge clk)
    begin
        if (en.s4)
        begin
            delta4_reg <= $signed({1'b0, second_num}) - $signed({1'b0, first_num});
            inc4_reg   <= include_end;
            bad4_reg   <= !both_ok;
        end
    end

    // magnitude + include_end keeps the sign: subtract when negative, add otherwise
    always_comb
    begin
        if (delta4_reg < 0)
            sum = SUM_W'(delta4_reg) - SUM_W'(inc4_reg);
        else
            sum = SUM_W'(delta4_reg) + SUM_W'(inc4_reg);

        if (bad4_reg)
            diff_next = '0;
        else if (sum > $signed(SUM_W'(DIFF_MAX)))
            diff_next = DIFF_W'(DIFF_MAX);
        else if (sum < -$signed(SUM_W'(DIFF_MAX)))
            diff_next = -$signed(DIFF_W'(DIFF_MAX));
        else
            diff_next = DIFF_W'(sum);
    end

    always_ff @(posedge clk)
    begin
        if (en.s5)
        begin
            diff5_reg <= diff_next;
            bad5_reg  <= bad4_reg;
        end
    end

    assign diff    = diff5_reg;
    assign invalid = bad5_reg;

endmodule

@@ rtl/gregorian_date_difference_top.sv @@
// Gregorian date difference, top level: flow control, valid pipeline, assertions.
// Depends on gdd_pkg, gdd_day_num and gdd_diff.
//
// Input channel: in_valid / in_stall with the two dates and include_end_day.
// A transaction is taken at a rising edge with in_valid high and in_stall low.
// Output channel: out_valid / out_stall with day_difference (signed days from
// the first date to the second) and date_invalid (either date out of range;
// the difference is then zero).
// Five register stages: divide-by-100 multiply, calendar check and leap
// correction, day-number sum, subtract, end-day adjust with saturation.
// out_valid rises when a transaction reaches the last stage; one transaction per
// cycle is sustained while out_stall is low. Each stage advances when it is
// empty or the stage after it advances, so bubbles are squeezed out under stall.
// in_stall rises only when every stage holds an item and out_stall is high;
// a stalled result holds its value until taken.
// Reset clears all stage valid bits; the block is ready the cycle after.
module gregorian_date_difference_top (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic [gdd_pkg::DAY_W-1:0]     first_day,
    input  logic [gdd_pkg::MONTH_W-1:0]   first_month,
    input  logic [gdd_pkg::YEAR_W-1:0]    first_year,
    input  logic [gdd_pkg::DAY_W-1:0]     second_day,
    input  logic [gdd_pkg::MONTH_W-1:0]   second_month,
    input  logic [gdd_pkg::YEAR_W-1:0]    second_year,
    input  logic                          include_end_day,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic signed [gdd_pkg::DIFF_W-1:0] day_difference,
    output logic                          date_invalid
);
    import gdd_pkg::*;

    localparam int STAGES = 5;

    logic [STAGES-1:0] v_reg;
    logic [STAGES-1:0] v_next;
    logic [STAGES-1:0] ready;

    logic inc1_reg;
    logic inc2_reg;
    logic inc3_reg;

    gdd_dn_en_t   dn_en;
    gdd_diff_en_t diff_en;

    logic [DN_W-1:0] first_num;
    logic [DN_W-1:0] second_num;
    logic            first_ok;
    logic            second_ok;

    always_comb
    begin
        ready[STAGES-1] = !v_reg[STAGES-1] || !out_stall;
        for (int i = STAGES - 2; i >= 0; i--)
            ready[i] = !v_reg[i] || ready[i+1];

        v_next[0] = ready[0] ? in_valid : v_reg[0];
        for (int i = 1; i < STAGES; i++)
            v_next[i] = ready[i] ? v_reg[i-1] : v_reg[i];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_reg <= '0;
        else
            v_reg <= v_next;
    end

    assign dn_en.s1   = ready[0];
    assign dn_en.s2   = ready[1];
    assign dn_en.s3   = ready[2];
    assign diff_en.s4 = ready[3];
    assign diff_en.s5 = ready[4];

    always_ff @(posedge clk)
    begin
        if (dn_en.s1)
            inc1_reg <= include_end_day;
        if (dn_en.s2)
            inc2_reg <= inc1_reg;
        if (dn_en.s3)
            inc3_reg <= inc2_reg;
    end

    gdd_day_num u_first (
        .clk     (clk),
        .en      (dn_en),
        .day     (first_day),
        .month   (first_month),
        .year    (first_year),
        .day_num (first_num),
        .date_ok (first_ok)
    );

    gdd_day_num u_second (
        .clk     (clk),
        .en      (dn_en),
        .day     (second_day),
        .month   (second_month),
        .year    (second_year),
        .day_num (second_num),
        .date_ok (second_ok)
    );

    gdd_diff u_diff (
        .clk         (clk),
        .en          (diff_en),
        .first_num   (first_num),
        .second_num  (second_num),
        .both_ok     (first_ok && second_ok),
        .include_end (inc3_reg),
        .diff        (day_difference),
        .invalid     (date_invalid)
    );

    assign in_stall  = !ready[0];
    assign out_valid = v_reg[STAGES-1];

    a_invalid_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && date_invalid |-> day_difference == '0)
        else $error("invalid date with nonzero difference");

    a_stall_only_full: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> out_valid && out_stall && (&v_reg))
        else $error("input stalled with room in the pipeline");

    a_saturated_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> day_difference != -$signed(DIFF_W'(DIFF_MAX)) - DIFF_W'(1))
        else $error("difference beyond saturation limit");

endmodule
